### hdl/snn_pkg.sv
// Shared constants, codes and saturation helper for the spiking neuron step unit.
package snn_pkg;

   localparam int NEURONS_DEF   = 64;
   localparam int FRAC_BITS_DEF = 16;
   localparam int EXT_W         = 80;

   localparam logic [1:0] KIND_LOAD_NEURON = 2'd0;
   localparam logic [1:0] KIND_LOAD_WEIGHT = 2'd1;
   localparam logic [1:0] KIND_SET_CURRENT = 2'd2;
   localparam logic [1:0] KIND_STEP        = 2'd3;

   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_ACTIVE    = 1'b1;

   localparam logic signed [31:0] THRESHOLD_RESET = 32'sd1966080;
   localparam logic [6:0]         ACTIVE_RESET    = 7'd64;

   localparam logic signed [EXT_W-1:0] SAT_MAX = EXT_W'(64'sd2147483647);
   localparam logic signed [EXT_W-1:0] SAT_MIN = -EXT_W'(64'sd2147483648);

   function automatic logic signed [31:0] sat32(input logic signed [EXT_W-1:0] x);
      logic signed [31:0] r;
      if (x > SAT_MAX) begin
         r = 32'sh7FFFFFFF;
      end else if (x < SAT_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

### hdl/snn_ram.sv
// Generic single-write, single-read RAM with registered read data.
module snn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/spiking_neuron_network_step_unit.sv
// Izhikevich neuron network step unit: loads and time steps on one shared multiplier.
// Loads are reported in the cycle after start, one load per cycle while busy is low.
// A step holds busy through a fire pass over the N active neurons, then per neuron
// one weight read per source neuron and the shared multiplier sequence.
// One item at a time: busy drops in the cycle the step result is strobed; rsp_valid
// lasts one cycle and is not held. Synchronous reset clears control, currents and mask.
module spiking_neuron_network_step_unit #(
   parameter int NEURONS   = snn_pkg::NEURONS_DEF,
   parameter int FRAC_BITS = snn_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_kind,
   input  logic [5:0]         req_neuron,
   input  logic [5:0]         req_source,
   input  logic signed [31:0] req_param_a,
   input  logic signed [31:0] req_param_b,
   input  logic signed [31:0] req_param_c,
   input  logic signed [31:0] req_param_d,
   input  logic signed [31:0] req_start_potential,
   input  logic signed [31:0] req_start_recovery,
   input  logic signed [31:0] req_weight_or_current,
   output logic               rsp_valid,
   output logic [63:0]        rsp_fired_mask,
   output logic               rsp_done_kind,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [31:0]        csr_wr_data
);

   localparam int XW  = snn_pkg::EXT_W;
   localparam int IW  = $clog2(NEURONS);
   localparam int CW  = $clog2(NEURONS + 1);
   localparam int WAW = $clog2(NEURONS * NEURONS);
   localparam int K   = ((4 << FRAC_BITS) + 50) / 100;
   localparam logic signed [XW-1:0] RND_F = XW'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [XW-1:0] C140  = XW'(140) <<< FRAC_BITS;
   localparam logic signed [32:0]   K_OP  = 33'(K);

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_F_RD  = 5'd1;
   localparam logic [4:0] ST_F_WR  = 5'd2;
   localparam logic [4:0] ST_N_RD  = 5'd3;
   localparam logic [4:0] ST_N_LAT = 5'd4;
   localparam logic [4:0] ST_N_ACC = 5'd5;
   localparam logic [4:0] ST_N_SAT = 5'd6;
   localparam logic [4:0] ST_H_SQ  = 5'd7;
   localparam logic [4:0] ST_H_RS  = 5'd8;
   localparam logic [4:0] ST_H_LO  = 5'd9;
   localparam logic [4:0] ST_H_HI  = 5'd10;
   localparam logic [4:0] ST_H_T   = 5'd11;
   localparam logic [4:0] ST_H_A1  = 5'd12;
   localparam logic [4:0] ST_H_A2  = 5'd13;
   localparam logic [4:0] ST_U_BV  = 5'd14;
   localparam logic [4:0] ST_U_SAT = 5'd15;
   localparam logic [4:0] ST_U_DIF = 5'd16;
   localparam logic [4:0] ST_U_AU  = 5'd17;
   localparam logic [4:0] ST_U_WR  = 5'd18;
   localparam logic [4:0] ST_DONE  = 5'd19;

   logic [4:0]               state_ff;
   logic                     busy_ff;
   logic [CW-1:0]            i_ff, j_ff;
   logic [IW-1:0]            jd_ff;
   logic                     wv_ff, h_ff;
   logic [NEURONS-1:0]       mask_ff, cur_vld_ff;
   logic                     cur_vld_rd_ff;
   logic signed [39:0]       acc_ff;
   logic signed [31:0]       v_ff, u_ff, a_ff, b_ff, cur_ff, bv_ff, diff_ff;
   logic [63:0]              sq_ff;
   logic signed [65:0]       lo_ff, prod_ff;
   logic signed [XW-1:0]     term_ff, e_ff;
   logic signed [31:0]       thr_ff;
   logic [6:0]               act_ff;
   logic                     rsp_valid_ff, rsp_kind_ff;
   logic [63:0]              rsp_mask_ff;

   logic [CW-1:0]            cnt;
   logic [IW-1:0]            i_idx, n_idx, s_idx;
   logic                     accept, n_ok, s_ok, fire_hit;
   logic signed [32:0]       mul_a, mul_b;
   logic signed [XW-1:0]     dv;
   logic signed [31:0]       v_in, u_in, fu_in;

   logic                     prm_we, vu_we, cur_we, w_we;
   logic [IW-1:0]            vu_wa;
   logic [63:0]              vu_wd;
   logic [127:0]             prm_rd;
   logic [63:0]              vu_rd;
   logic [31:0]              cur_rd, w_rd;
   logic [WAW-1:0]           w_wa, w_ra;
   logic signed [31:0]       rd_a, rd_b, rd_c, rd_d, rd_v, rd_u, rd_w;

   assign cnt    = (act_ff > 7'(NEURONS)) ? CW'(NEURONS) : CW'(act_ff);
   assign i_idx  = i_ff[IW-1:0];
   assign n_idx  = req_neuron[IW-1:0];
   assign s_idx  = req_source[IW-1:0];
   assign accept = start && !busy_ff;
   assign n_ok   = 7'(req_neuron) < 7'(NEURONS);
   assign s_ok   = 7'(req_source) < 7'(NEURONS);

   assign rd_a = $signed(prm_rd[127:96]);
   assign rd_b = $signed(prm_rd[95:64]);
   assign rd_c = $signed(prm_rd[63:32]);
   assign rd_d = $signed(prm_rd[31:0]);
   assign rd_v = $signed(vu_rd[63:32]);
   assign rd_u = $signed(vu_rd[31:0]);
   assign rd_w = $signed(w_rd);

   assign fire_hit = rd_v >= thr_ff;
   assign fu_in    = snn_pkg::sat32(XW'(rd_u) + XW'(rd_d));
   assign dv       = e_ff + C140 + XW'(cur_ff);
   assign v_in     = snn_pkg::sat32(XW'(v_ff) + ((dv + XW'(1)) >>> 1));
   assign u_in     = snn_pkg::sat32(XW'(u_ff) + ((XW'(prod_ff) + RND_F) >>> FRAC_BITS));

   assign w_wa = WAW'(n_idx * NEURONS + s_idx);
   assign w_ra = WAW'(i_idx * NEURONS + j_ff);

   always_comb begin
      prm_we = accept && n_ok && (req_kind == snn_pkg::KIND_LOAD_NEURON);
      w_we   = accept && n_ok && s_ok && (req_kind == snn_pkg::KIND_LOAD_WEIGHT);
      cur_we = accept && n_ok && (req_kind == snn_pkg::KIND_SET_CURRENT);
      vu_we  = 1'b0;
      vu_wa  = i_idx;
      vu_wd  = {v_ff, u_in};
      unique case (state_ff)
         ST_IDLE: begin
            vu_we = prm_we;
            vu_wa = n_idx;
            vu_wd = {req_start_potential, req_start_recovery};
         end
         ST_F_WR: begin
            vu_we = fire_hit;
            vu_wd = {rd_c, fu_in};
         end
         ST_U_WR: begin
            vu_we = 1'b1;
         end
         default: begin
            vu_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      unique case (state_ff)
         ST_H_SQ: begin
            mul_a = 33'(v_ff);
            mul_b = 33'(v_ff);
         end
         ST_H_LO: begin
            mul_a = $signed({9'b0, sq_ff[23:0]});
            mul_b = K_OP;
         end
         ST_H_HI: begin
            mul_a = $signed({1'b0, sq_ff[55:24]});
            mul_b = K_OP;
         end
         ST_U_BV: begin
            mul_a = 33'(b_ff);
            mul_b = 33'(v_ff);
         end
         ST_U_AU: begin
            mul_a = 33'(a_ff);
            mul_b = 33'(diff_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   snn_ram #(.WIDTH(128), .DEPTH(NEURONS)) u_prm_ram (
      .clock   (clock),
      .wr_en   (prm_we),
      .wr_addr (n_idx),
      .wr_data ({req_param_a, req_param_b, req_param_c, req_param_d}),
      .rd_addr (i_idx),
      .rd_data (prm_rd)
   );

   snn_ram #(.WIDTH(64), .DEPTH(NEURONS)) u_vu_ram (
      .clock   (clock),
      .wr_en   (vu_we),
      .wr_addr (vu_wa),
      .wr_data (vu_wd),
      .rd_addr (i_idx),
      .rd_data (vu_rd)
   );

   snn_ram #(.WIDTH(32), .DEPTH(NEURONS)) u_cur_ram (
      .clock   (clock),
      .wr_en   (cur_we),
      .wr_addr (n_idx),
      .wr_data (req_weight_or_current),
      .rd_addr (i_idx),
      .rd_data (cur_rd)
   );

   snn_ram #(.WIDTH(32), .DEPTH(NEURONS * NEURONS)) u_w_ram (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (w_wa),
      .wr_data (req_weight_or_current),
      .rd_addr (w_ra),
      .rd_data (w_rd)
   );

   always_ff @(posedge clock) begin
      prod_ff       <= mul_a * mul_b;
      cur_vld_rd_ff <= cur_vld_ff[i_idx];
      unique case (state_ff)
         ST_N_LAT: begin
            v_ff   <= rd_v;
            u_ff   <= rd_u;
            a_ff   <= rd_a;
            b_ff   <= rd_b;
            acc_ff <= cur_vld_rd_ff ? 40'(signed'(cur_rd)) : '0;
         end
         ST_N_ACC: begin
            if (wv_ff && mask_ff[jd_ff]) begin
               acc_ff <= acc_ff + 40'(rd_w);
            end
         end
         ST_N_SAT: cur_ff  <= snn_pkg::sat32(XW'(acc_ff));
         ST_H_RS:  sq_ff   <= 64'((XW'(prod_ff) + RND_F) >>> FRAC_BITS);
         ST_H_HI:  lo_ff   <= prod_ff;
         ST_H_T:   term_ff <= ((XW'(lo_ff) + (XW'(prod_ff) <<< 24)) + RND_F) >>> FRAC_BITS;
         ST_H_A1:  e_ff    <= term_ff + (XW'(v_ff) <<< 2) + XW'(v_ff) - XW'(u_ff);
         ST_H_A2:  v_ff    <= v_in;
         ST_U_SAT: bv_ff   <= snn_pkg::sat32((XW'(prod_ff) + RND_F) >>> FRAC_BITS);
         ST_U_DIF: diff_ff <= snn_pkg::sat32(XW'(bv_ff) - XW'(u_ff));
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         jd_ff        <= '0;
         wv_ff        <= 1'b0;
         h_ff         <= 1'b0;
         mask_ff      <= '0;
         cur_vld_ff   <= '0;
         thr_ff       <= snn_pkg::THRESHOLD_RESET;
         act_ff       <= snn_pkg::ACTIVE_RESET;
         rsp_valid_ff <= 1'b0;
         rsp_kind_ff  <= 1'b0;
         rsp_mask_ff  <= '0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_DONE) ||
                         (accept && (state_ff == ST_IDLE) &&
                          (req_kind != snn_pkg::KIND_STEP));
         if (csr_wr_en) begin
            unique case (csr_index)
               snn_pkg::CSR_THRESHOLD: thr_ff <= $signed(csr_wr_data);
               snn_pkg::CSR_ACTIVE:    act_ff <= csr_wr_data[6:0];
            endcase
         end
         if (cur_we) begin
            cur_vld_ff[n_idx] <= 1'b1;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_kind == snn_pkg::KIND_STEP) begin
                     busy_ff  <= 1'b1;
                     mask_ff  <= '0;
                     i_ff     <= '0;
                     state_ff <= (cnt == '0) ? ST_DONE : ST_F_RD;
                  end else begin
                     rsp_kind_ff  <= 1'b0;
                     rsp_mask_ff  <= '0;
                  end
               end
            end
            ST_F_RD: state_ff <= ST_F_WR;
            ST_F_WR: begin
               if (fire_hit) begin
                  mask_ff[i_idx] <= 1'b1;
               end
               if (i_ff + 1'b1 == cnt) begin
                  i_ff     <= '0;
                  state_ff <= ST_N_RD;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= ST_F_RD;
               end
            end
            ST_N_RD: state_ff <= ST_N_LAT;
            ST_N_LAT: begin
               j_ff     <= '0;
               wv_ff    <= 1'b0;
               state_ff <= ST_N_ACC;
            end
            ST_N_ACC: begin
               if (j_ff < cnt) begin
                  wv_ff <= 1'b1;
                  jd_ff <= j_ff[IW-1:0];
                  j_ff  <= j_ff + 1'b1;
               end else begin
                  wv_ff <= 1'b0;
                  if (!wv_ff) begin
                     state_ff <= ST_N_SAT;
                  end
               end
            end
            ST_N_SAT: begin
               h_ff     <= 1'b0;
               state_ff <= ST_H_SQ;
            end
            ST_H_SQ: state_ff <= ST_H_RS;
            ST_H_RS: state_ff <= ST_H_LO;
            ST_H_LO: state_ff <= ST_H_HI;
            ST_H_HI: state_ff <= ST_H_T;
            ST_H_T:  state_ff <= ST_H_A1;
            ST_H_A1: state_ff <= ST_H_A2;
            ST_H_A2: begin
               h_ff     <= 1'b1;
               state_ff <= h_ff ? ST_U_BV : ST_H_SQ;
            end
            ST_U_BV:  state_ff <= ST_U_SAT;
            ST_U_SAT: state_ff <= ST_U_DIF;
            ST_U_DIF: state_ff <= ST_U_AU;
            ST_U_AU:  state_ff <= ST_U_WR;
            ST_U_WR: begin
               if (i_ff + 1'b1 == cnt) begin
                  state_ff <= ST_DONE;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= ST_N_RD;
               end
            end
            ST_DONE: begin
               rsp_kind_ff  <= 1'b1;
               rsp_mask_ff  <= 64'(mask_ff);
               busy_ff      <= 1'b0;
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy           = busy_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fired_mask = rsp_mask_ff;
   assign rsp_done_kind  = rsp_kind_ff;

endmodule

### hdl/snn_checker.sv
// Port-level checker for the spiking neuron step unit and its bind.
module snn_assertions (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_kind,
   input logic        rsp_valid,
   input logic [63:0] rsp_fired_mask,
   input logic        rsp_done_kind
);

   a_load_reply: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_kind != snn_pkg::KIND_STEP) |=> rsp_valid && !rsp_done_kind)
      else $error("load item not answered in the next cycle");

   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_kind == snn_pkg::KIND_STEP) |=> busy && !rsp_valid)
      else $error("step item did not raise busy");

   a_step_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_kind |-> !busy && $past(busy))
      else $error("step result without end of busy");

   a_load_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_kind |-> rsp_fired_mask == 64'd0)
      else $error("load result carries a fired mask");

endmodule

bind spiking_neuron_network_step_unit snn_assertions u_snn_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_kind       (req_kind),
   .rsp_valid      (rsp_valid),
   .rsp_fired_mask (rsp_fired_mask),
   .rsp_done_kind  (rsp_done_kind)
);

### bench/snn_checker.sv
// Checker for the spiking neuron step unit: predicts each item's result and compares.
module snn_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_kind,
   input  logic [5:0]         req_neuron,
   input  logic [5:0]         req_source,
   input  logic signed [31:0] req_param_a,
   input  logic signed [31:0] req_param_b,
   input  logic signed [31:0] req_param_c,
   input  logic signed [31:0] req_param_d,
   input  logic signed [31:0] req_start_potential,
   input  logic signed [31:0] req_start_recovery,
   input  logic signed [31:0] req_weight_or_current,
   input  logic               rsp_valid,
   input  logic [63:0]        rsp_fired_mask,
   input  logic               rsp_done_kind,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [31:0]        csr_wr_data,
   output int                 failures,
   output int                 pending
);

   typedef struct packed {
      logic [63:0] mask;
      logic        done;
   } outcome_type;

   outcome_type awaited[$];

   longint v_mem[64];
   longint u_mem[64];
   longint a_mem[64];
   longint b_mem[64];
   longint c_mem[64];
   longint d_mem[64];
   longint drive_mem[64];
   longint weight_mem[4096];
   longint fire_level;
   int     active_count;

   function automatic longint clamp32(input longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint round_shift(input longint x, input int s);
      return (x + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint slope(input longint v, input longint u, input longint i);
      longint sq;
      sq = round_shift(v * v, 16);
      return round_shift(sq * 64'sd2621, 16) + 5 * v + (64'sd140 <<< 16) - u + i;
   endfunction

   function automatic logic [63:0] advance_network();
      logic [63:0] fired;
      longint      cur, v, u, bv, diff;
      int          n;
      fired = '0;
      n = (active_count > 64) ? 64 : active_count;
      for (int i = 0; i < n; i++) begin
         if (v_mem[i] >= fire_level) begin
            fired[i] = 1'b1;
            v_mem[i] = c_mem[i];
            u_mem[i] = clamp32(u_mem[i] + d_mem[i]);
         end
      end
      for (int i = 0; i < n; i++) begin
         cur = drive_mem[i];
         for (int j = 0; j < n; j++) begin
            if (fired[j]) cur += weight_mem[i * 64 + j];
         end
         cur = clamp32(cur);
         v = v_mem[i];
         u = u_mem[i];
         v = clamp32(v + round_shift(slope(v, u, cur), 1));
         v = clamp32(v + round_shift(slope(v, u, cur), 1));
         bv = clamp32(round_shift(b_mem[i] * v, 16));
         diff = clamp32(bv - u);
         u = clamp32(u + round_shift(a_mem[i] * diff, 16));
         v_mem[i] = v;
         u_mem[i] = u;
      end
      return fired;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         awaited.delete();
         failures = 0;
         fire_level = longint'(snn_pkg::THRESHOLD_RESET);
         active_count = int'(snn_pkg::ACTIVE_RESET);
         for (int i = 0; i < 64; i++) drive_mem[i] = 0;
      end else begin
         if (rsp_valid) begin
            if (awaited.size() == 0) begin
               failures++;
               $display("%0t: unexpected result mask=%h done=%b", $time,
                        rsp_fired_mask, rsp_done_kind);
            end else begin
               want = awaited.pop_front();
               if (rsp_fired_mask !== want.mask) begin
                  failures++;
                  $display("%0t: fired_mask expected %h actual %h", $time,
                           want.mask, rsp_fired_mask);
               end
               if (rsp_done_kind !== want.done) begin
                  failures++;
                  $display("%0t: done_kind expected %b actual %b", $time,
                           want.done, rsp_done_kind);
               end
            end
         end
         if (csr_wr_en) begin
            if (csr_index == snn_pkg::CSR_THRESHOLD) begin
               fire_level = longint'($signed(csr_wr_data));
            end else begin
               active_count = int'(csr_wr_data[6:0]);
            end
         end
         if (start && !busy) begin
            want.mask = '0;
            want.done = 1'b0;
            case (req_kind)
               snn_pkg::KIND_LOAD_NEURON: begin
                  a_mem[req_neuron] = req_param_a;
                  b_mem[req_neuron] = req_param_b;
                  c_mem[req_neuron] = req_param_c;
                  d_mem[req_neuron] = req_param_d;
                  v_mem[req_neuron] = req_start_potential;
                  u_mem[req_neuron] = req_start_recovery;
               end
               snn_pkg::KIND_LOAD_WEIGHT: begin
                  weight_mem[req_neuron * 64 + req_source] = req_weight_or_current;
               end
               snn_pkg::KIND_SET_CURRENT: begin
                  drive_mem[req_neuron] = req_weight_or_current;
               end
               default: begin
                  want.mask = advance_network();
                  want.done = 1'b1;
               end
            endcase
            awaited.push_back(want);
         end
      end
      pending = awaited.size();
   end

endmodule

### bench/tb_spiking_neuron_network_step_unit.sv
// Testbench top for the spiking neuron step unit: stimulus, watchdog and verdict.
module tb_spiking_neuron_network_step_unit;

   localparam int IDLE_LIMIT = 100000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_kind;
   logic [5:0]         req_neuron;
   logic [5:0]         req_source;
   logic signed [31:0] req_param_a;
   logic signed [31:0] req_param_b;
   logic signed [31:0] req_param_c;
   logic signed [31:0] req_param_d;
   logic signed [31:0] req_start_potential;
   logic signed [31:0] req_start_recovery;
   logic signed [31:0] req_weight_or_current;
   logic               rsp_valid;
   logic [63:0]        rsp_fired_mask;
   logic               rsp_done_kind;
   logic               csr_wr_en;
   logic               csr_index;
   logic [31:0]        csr_wr_data;
   int                 failures;
   int                 pending;
   int                 idle_cycles;
   int                 active_now;

   spiking_neuron_network_step_unit i_dut (.*);

   snn_checker i_checker (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("** spiking_neuron_network_step_unit: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send(input logic [1:0] kind, input logic [5:0] n, input logic [5:0] s,
                       input logic [31:0] a, input logic [31:0] b, input logic [31:0] c,
                       input logic [31:0] d, input logic [31:0] v, input logic [31:0] u,
                       input logic [31:0] w);
      int gap;
      gap = $urandom_range(0, 6);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      req_kind <= kind;
      req_neuron <= n;
      req_source <= s;
      req_param_a <= a;
      req_param_b <= b;
      req_param_c <= c;
      req_param_d <= d;
      req_start_potential <= v;
      req_start_recovery <= u;
      req_weight_or_current <= w;
      start <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [31:0] data);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (index == snn_pkg::CSR_ACTIVE) active_now = int'(data[6:0]);
   endtask

   // resting-range neurons by default; wild ones draw every field at random
   task automatic load_neuron(input logic [5:0] n, input logic allow_wild);
      logic [31:0] v;
      if (!allow_wild || $urandom_range(0, 9) < 8) begin
         v = -(65 <<< 16) + $urandom_range(0, 100 <<< 16);
         send(snn_pkg::KIND_LOAD_NEURON, n, 6'($urandom),
              32'd1311 + $urandom_range(0, 6000), 32'd13107 + $urandom_range(0, 4000),
              -((50 + $urandom_range(0, 15)) <<< 16), $urandom_range(1, 8) <<< 16,
              v, -(13 <<< 16), $urandom);
      end else begin
         send(snn_pkg::KIND_LOAD_NEURON, n, 6'($urandom), $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   task automatic load_weight(input logic [5:0] n, input logic [5:0] s);
      logic [31:0] w;
      if ($urandom_range(0, 9) < 8) w = $urandom_range(0, 20 <<< 16) - (10 <<< 16);
      else w = $urandom;
      send(snn_pkg::KIND_LOAD_WEIGHT, n, s, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, w);
   endtask

   task automatic set_current(input logic [5:0] n);
      logic [31:0] w;
      if ($urandom_range(0, 9) < 8) w = $urandom_range(0, 20 <<< 16);
      else w = $urandom;
      send(snn_pkg::KIND_SET_CURRENT, n, 6'($urandom), $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, w);
   endtask

   task automatic time_step();
      send(snn_pkg::KIND_STEP, 6'($urandom), 6'($urandom), $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic random_phase(input int count);
      logic [5:0] n;
      int         span;
      for (int k = 0; k < count; k++) begin
         span = (active_now < 1) ? 1 : ((active_now > 64) ? 64 : active_now);
         n = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, span - 1));
         case ($urandom_range(0, 3))
            0: time_step();
            1: load_neuron(n, 1'b1);
            2: load_weight(n, ($urandom_range(0, 3) == 0) ? 6'($urandom)
                                                        : 6'($urandom_range(0, span - 1)));
            default: set_current(n);
         endcase
         if (k == count / 2 && $urandom_range(0, 1) == 0) drain();
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_kind = snn_pkg::KIND_LOAD_NEURON;
      req_neuron = '0;
      req_source = '0;
      req_param_a = '0;
      req_param_b = '0;
      req_param_c = '0;
      req_param_d = '0;
      req_start_potential = '0;
      req_start_recovery = '0;
      req_weight_or_current = '0;
      csr_wr_en = 1'b0;
      csr_index = snn_pkg::CSR_THRESHOLD;
      csr_wr_data = '0;
      active_now = 64;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < 64; i++) load_neuron(6'(i), 1'b0);

      // full network (active count above and at 64), then none active, with a firing level no resting neuron reaches
      write_csr(snn_pkg::CSR_THRESHOLD, 32'h7FFFFFFF);
      write_csr(snn_pkg::CSR_ACTIVE, 32'd127);
      time_step();
      write_csr(snn_pkg::CSR_ACTIVE, 32'd64);
      time_step();
      write_csr(snn_pkg::CSR_ACTIVE, 32'd0);
      time_step();

      write_csr(snn_pkg::CSR_THRESHOLD, 32'(30 <<< 16));
      write_csr(snn_pkg::CSR_ACTIVE, 32'd4);
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) load_weight(6'(i), 6'(j));
      end

      // extremes of every field, then steps that saturate
      send(snn_pkg::KIND_LOAD_NEURON, 6'd3, 6'd3, 32'h7FFFFFFF, 32'h7FFFFFFF,
           32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send(snn_pkg::KIND_LOAD_NEURON, 6'd0, 6'd0, 32'h80000000, 32'h80000000,
           32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
      send(snn_pkg::KIND_LOAD_WEIGHT, 6'd3, 6'd3, 0, 0, 0, 0, 0, 0, 32'h7FFFFFFF);
      send(snn_pkg::KIND_LOAD_WEIGHT, 6'd0, 6'd3, 0, 0, 0, 0, 0, 0, 32'h80000000);
      send(snn_pkg::KIND_SET_CURRENT, 6'd3, 6'd0, 0, 0, 0, 0, 0, 0, 32'h7FFFFFFF);
      send(snn_pkg::KIND_SET_CURRENT, 6'd0, 6'd0, 0, 0, 0, 0, 0, 0, 32'h80000000);
      time_step();
      time_step();
      send(snn_pkg::KIND_SET_CURRENT, 6'd3, 6'd0, 0, 0, 0, 0, 0, 0, 32'd0);
      send(snn_pkg::KIND_SET_CURRENT, 6'd0, 6'd0, 0, 0, 0, 0, 0, 0, 32'd0);
      load_neuron(6'd0, 1'b0);
      load_neuron(6'd3, 1'b0);

      write_csr(snn_pkg::CSR_THRESHOLD, 32'h80000000);
      write_csr(snn_pkg::CSR_ACTIVE, 32'd3);
      time_step();
      write_csr(snn_pkg::CSR_THRESHOLD, 32'h7FFFFFFF);
      write_csr(snn_pkg::CSR_ACTIVE, 32'd1);
      time_step();
      write_csr(snn_pkg::CSR_THRESHOLD, 32'(30 <<< 16));
      write_csr(snn_pkg::CSR_ACTIVE, 32'd2);
      time_step();
      time_step();

      write_csr(snn_pkg::CSR_ACTIVE, 32'd4);
      random_phase(12);
      write_csr(snn_pkg::CSR_THRESHOLD, 32'(10 <<< 16));
      random_phase(12);
      write_csr(snn_pkg::CSR_THRESHOLD, 32'h80000000);
      write_csr(snn_pkg::CSR_ACTIVE, 32'd2);
      random_phase(8);
      write_csr(snn_pkg::CSR_THRESHOLD, $urandom);
      write_csr(snn_pkg::CSR_ACTIVE, 32'($urandom_range(1, 4)));
      random_phase(8);
      write_csr(snn_pkg::CSR_ACTIVE, 32'd0);
      random_phase(5);

      drain();
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("** spiking_neuron_network_step_unit: PASSED **");
      end else begin
         $display("** spiking_neuron_network_step_unit: FAILED **");
      end
      $finish;
   end

endmodule
